@@ src/kvct_pkg.sv @@
// Shared types and constants for the key/value associative table.
// Used by kvct_cell, kvct_out and key_value_cam_table; depends on nothing.
package kvct_pkg;

    localparam int KeyWidth   = 64;
    localparam int ValueWidth = 64;

    // Command codes.
    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;

    // Incoming request payload.
    typedef struct packed {
        logic                  command;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] value;
    } kvct_cmd_t;

    // Outgoing result payload.
    typedef struct packed {
        logic [2:0]            status;
        logic [ValueWidth-1:0] read_value;
    } kvct_rsp_t;

    // Request as it travels along the row of cells.
    typedef struct packed {
        logic                  valid;
        logic                  command;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] data;
        logic [2:0]            status;
        logic                  done;
    } kvct_req_t;

endpackage

@@ src/kvct_cell.sv @@
// One table entry of the key/value table, with the request register that
// passes a request on to the next entry. Depends on kvct_pkg.
module kvct_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kvct_pkg::kvct_req_t req_in,
    output kvct_pkg::kvct_req_t req_out
);
    import kvct_pkg::*;

    logic                  occ_reg;
    logic                  occ_next;
    logic [KeyWidth-1:0]   key_reg;
    logic [KeyWidth-1:0]   key_next;
    logic [ValueWidth-1:0] val_reg;
    logic [ValueWidth-1:0] val_next;
    kvct_req_t             req_reg;
    kvct_req_t             req_next;
    logic                  hit;
    logic                  ins;

    // Compare the passing request against this entry and decide what it does here.
    always_comb
    begin
        hit      = req_in.valid && !req_in.done && occ_reg && (key_reg == req_in.key);
        ins      = req_in.valid && !req_in.done && !occ_reg && (req_in.command == CMD_SET);
        req_next = req_in;
        occ_next = occ_reg;
        key_next = key_reg;
        val_next = val_reg;
        if (hit)
        begin
            req_next.done = 1'b1;
            if (req_in.command == CMD_SET)
            begin
                req_next.status = ST_UPDATED;
                val_next        = req_in.data;
            end
            else
            begin
                req_next.status = ST_FOUND;
                req_next.data   = val_reg;
            end
        end
        else if (ins)
        begin
            // Entries fill in order, so the first empty entry reached takes the key.
            req_next.done   = 1'b1;
            req_next.status = ST_INSERTED;
            occ_next        = 1'b1;
            key_next        = req_in.key;
            val_next        = req_in.data;
        end
    end

    // Entry state and request register move only when the row advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            req_reg <= '0;
        end
        else if (advance)
        begin
            occ_reg <= occ_next;
            req_reg <= req_next;
        end
    end

    // Key and value payload need no reset: an empty entry is never compared.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_next;
            val_reg <= val_next;
        end
    end

    assign req_out = req_reg;

endmodule

@@ src/kvct_out.sv @@
// Output register of the key/value table: turns the request leaving the
// last entry into a result and holds it until taken. Depends on kvct_pkg.
module kvct_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  kvct_pkg::kvct_req_t req_in,
    output logic                rsp_valid,
    output kvct_pkg::kvct_rsp_t rsp_data
);
    import kvct_pkg::*;

    logic      valid_reg;
    kvct_rsp_t rsp_reg;
    kvct_rsp_t rsp_next;

    // A request that no entry resolved is either a full table or a missing key.
    always_comb
    begin
        rsp_next.status     = req_in.status;
        rsp_next.read_value = '0;
        if (!req_in.done)
        begin
            if (req_in.command == CMD_SET)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                rsp_next.status = ST_MISSING;
            end
        end
        if (rsp_next.status == ST_FOUND)
        begin
            rsp_next.read_value = req_in.data;
        end
    end

    // Result register; loads whenever the row advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

@@ src/key_value_cam_table.sv @@
// Top level of the key/value associative table: a row of ENTRIES cells
// followed by the output register. Depends on kvct_pkg, kvct_cell, kvct_out.
//
//  Channel   Direction  Handshake            Payload
//  cmd       in         cmd_valid/cmd_stall  kvct_cmd_t (command, key, value)
//  rsp       out        rsp_valid/rsp_stall  kvct_rsp_t (status, read_value)
//
// A request walks the row one entry per cycle while the row advances,
// through each entry's request register and then the output register;
// the row is a pipeline and takes one request every cycle while it advances.
// The whole row advances together; it holds while a result waits and
// rsp_stall is high, and cmd_stall is then high too.
// Reset marks every entry empty; there is no clearing pass.
module key_value_cam_table #(
    parameter int ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  kvct_pkg::kvct_cmd_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output kvct_pkg::kvct_rsp_t rsp
);
    import kvct_pkg::*;

    logic      advance;
    kvct_req_t head_req;
    kvct_req_t chain [ENTRIES+1];

    // The row moves when the output register is empty or being emptied.
    assign advance   = !rsp_valid || !rsp_stall;
    assign cmd_stall = !advance;

    // A zero key is resolved at once as missing; nothing downstream touches it.
    always_comb
    begin
        head_req.valid   = cmd_valid;
        head_req.command = cmd.command;
        head_req.key     = cmd.key;
        head_req.data    = cmd.value;
        head_req.status  = ST_MISSING;
        head_req.done    = (cmd.key == '0);
    end

    assign chain[0] = head_req;

    // Row of table entries.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kvct_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .req_in  (chain[i]),
            .req_out (chain[i+1])
        );
    end

    // Result formation and output register.
    kvct_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_in    (chain[ENTRIES]),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp)
    );

endmodule

@@ tb/tb_key_value_cam_table.sv @@
// Self-checking testbench for key_value_cam_table: directed and random set/get requests,
// with random idling on both channels, checked against a behavioural table model.
// Depends on kvct_pkg and the key_value_cam_table RTL.
module tb_key_value_cam_table;

    timeunit 1ns;
    timeprecision 1ps;

    import kvct_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_COUNT = 1425;
    localparam int CALM_COUNT   = 150;

    // Behavioural copy of the table and the queue of results still owed by the block.
    class kvct_scoreboard;
        logic [KeyWidth-1:0]   key_row[ENTRIES];
        logic [ValueWidth-1:0] value_row[ENTRIES];
        int                    filled;
        kvct_rsp_t             awaited_results[$];
        int                    mismatches;

        function new();
            foreach (key_row[i])
            begin
                key_row[i]   = '0;
                value_row[i] = '0;
            end
            filled     = 0;
            mismatches = 0;
        endfunction

        function bit holds_key(logic [KeyWidth-1:0] k);
            foreach (key_row[i])
            begin
                if (key_row[i] != '0 && key_row[i] == k)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Apply an accepted request to the table and note the result it must give.
        function void note_request(kvct_cmd_t c);
            kvct_rsp_t r;
            int        hit;
            int        slot;
            r.status     = ST_MISSING;
            r.read_value = '0;
            hit          = -1;
            slot         = -1;
            if (c.key != '0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (hit < 0 && key_row[i] == c.key)
                        hit = i;
                    if (slot < 0 && key_row[i] == '0)
                        slot = i;
                end
                if (c.command == CMD_SET)
                begin
                    if (hit >= 0)
                    begin
                        value_row[hit] = c.value;
                        r.status       = ST_UPDATED;
                    end
                    else if (slot >= 0)
                    begin
                        key_row[slot]   = c.key;
                        value_row[slot] = c.value;
                        filled++;
                        r.status        = ST_INSERTED;
                    end
                    else
                    begin
                        r.status = ST_FULL;
                    end
                end
                else if (hit >= 0)
                begin
                    r.status     = ST_FOUND;
                    r.read_value = value_row[hit];
                end
            end
            awaited_results.push_back(r);
        endfunction

        // Compare a delivered result with the oldest one owed.
        function void check_result(kvct_rsp_t got);
            kvct_rsp_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d read_value=%h",
                         $time, got.status, got.read_value);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value mismatch: expected %h, actual %h",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    kvct_cmd_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    kvct_rsp_t rsp;

    // Odds of idling: 0 means none, n means roughly one chance in n.
    int idle_odds = 0;

    kvct_scoreboard sb = new();

    key_value_cam_table #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    // Observe both handshakes on the edge where they complete.
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            sb.note_request(cmd);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // Receiver: stalls in random bursts while idling is enabled.
    always
    begin
        @(posedge clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            rsp_stall <= 1'b0;
        end
    end

    // Present one request and hold it until accepted, then perhaps pause.
    task automatic send_request(input logic op, input logic [KeyWidth-1:0] k,
                                input logic [ValueWidth-1:0] v);
        kvct_cmd_t c;
        c.command = op;
        c.key     = k;
        c.value   = v;
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // A nonzero key that the table does not hold yet.
    function automatic logic [KeyWidth-1:0] fresh_key();
        logic [KeyWidth-1:0] k;
        k = random_word();
        while (k == '0 || sb.holds_key(k))
            k = random_word();
        return k;
    endfunction

    function automatic logic [KeyWidth-1:0] stored_key();
        if (sb.filled == 0)
            return fresh_key();
        return sb.key_row[$urandom_range(0, sb.filled - 1)];
    endfunction

    // Main sequence.
    initial
    begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: empty table, invalid key, extremes, update, then fill and overflow.
        idle_odds = 3;
        send_request(CMD_GET, 64'h0000_0000_0000_0041, '1);
        send_request(CMD_SET, '0, '1);
        send_request(CMD_GET, '0, '1);
        send_request(CMD_SET, '1, '1);
        send_request(CMD_SET, 64'h0000_0000_0000_0001, '0);
        send_request(CMD_SET, 64'h0000_0000_4100_0042, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_SET, '1, '0);
        send_request(CMD_GET, '1, '0);
        send_request(CMD_GET, 64'h0000_0000_0000_0001, '1);
        send_request(CMD_GET, 64'h0000_0000_0000_4142, '0);
        while (sb.filled < ENTRIES)
            send_request(CMD_SET, fresh_key(), random_word());
        send_request(CMD_SET, fresh_key(), '1);
        send_request(CMD_GET, 64'h0000_0000_4100_0042, '0);

        // Let the block drain completely before the random part.
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);

        // Random requests, mostly against stored keys; idling varies by stretch.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n % 100 == 0)
            begin
                pick = $urandom_range(0, 2);
                idle_odds = (pick == 0) ? 0 : (pick == 1) ? 2 : 5;
            end
            if (n >= RANDOM_COUNT - CALM_COUNT)
                idle_odds = 0;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_request(CMD_SET, stored_key(), random_word());
            else if (pick < 65)
                send_request(CMD_GET, stored_key(), random_word());
            else if (pick < 75)
                send_request(CMD_SET, fresh_key(), random_word());
            else if (pick < 85)
                send_request(CMD_GET, random_word(), random_word());
            else if (pick < 92)
                send_request(1'($urandom_range(0, 1)),
                             stored_key() ^ (64'd1 << $urandom_range(0, 63)),
                             random_word());
            else
                send_request(1'($urandom_range(0, 1)), '0, random_word());
        end
        cmd_valid <= 1'b0;

        // Wait for the last results, then allow for anything stray.
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);

        if (sb.mismatches == 0)
            $display("** key_value_cam_table: PASSED **");
        else
            $display("** key_value_cam_table: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("** key_value_cam_table: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/kvct_pkg.sv
src/kvct_cell.sv
src/kvct_out.sv
src/key_value_cam_table.sv
tb/tb_key_value_cam_table.sv
